FILE: rtl/assert_macros.svh
// Shared assertion macros for the display driver checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DVSD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DVSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/dvsd_pkg.sv
package dvsd_pkg;

  // The display has eight positions, one select bit each.
  localparam int unsigned Positions = 8;
  localparam int unsigned PosW = 3;

  localparam int unsigned ValueW = 16;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SegW = 8;

  // Decimal point is bit 7 of the active-low segment byte.
  localparam logic [SegW-1:0] DpBit = 8'h80;

  // Division by ten through a reciprocal: q = (v * 52429) >> 19 is exact for 16-bit v.
  localparam logic [ValueW-1:0] Recip10 = 16'd52429;
  localparam int unsigned Recip10Shift = 19;

  typedef struct packed {
    logic [Positions-1:0] digit_select;
    logic [SegW-1:0]      segments;
    logic                 last_frame;
  } frame_t;

  // Active-low patterns for the decimal digits; other codes blank the digit.
  function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0: seg = 8'hC0;
      4'd1: seg = 8'hF9;
      4'd2: seg = 8'hA4;
      4'd3: seg = 8'hB0;
      4'd4: seg = 8'h99;
      4'd5: seg = 8'h92;
      4'd6: seg = 8'h82;
      4'd7: seg = 8'hF8;
      4'd8: seg = 8'h80;
      4'd9: seg = 8'h90;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/dvsd_in_if.sv
interface dvsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] measured_value;
  logic [15:0] target_value;

  modport source (output valid, output measured_value, output target_value, input ready);
  modport sink (input valid, input measured_value, input target_value, output ready);
endinterface

FILE: rtl/dvsd_out_if.sv
interface dvsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_select;
  logic [7:0] segments;
  logic       last_frame;

  modport source (output valid, output digit_select, output segments, output last_frame,
                  input ready);
  modport sink (input valid, input digit_select, input segments, input last_frame,
                output ready);
endinterface

FILE: rtl/dvsd_div10.sv
module dvsd_div10 (
  input  logic [dvsd_pkg::ValueW-1:0] value,
  output logic [dvsd_pkg::ValueW-1:0] quotient,
  output logic [dvsd_pkg::DigitW-1:0] digit
);

  logic [2*dvsd_pkg::ValueW-1:0] product;
  logic [dvsd_pkg::ValueW-1:0]   times_ten;
  logic [dvsd_pkg::ValueW-1:0]   remainder;

  // Quotient by reciprocal multiply, remainder by shift-and-add back out.
  always_comb begin
    product   = (2*dvsd_pkg::ValueW)'(value) * (2*dvsd_pkg::ValueW)'(dvsd_pkg::Recip10);
    quotient  = dvsd_pkg::ValueW'(product >> dvsd_pkg::Recip10Shift);
    times_ten = (quotient << 3) + (quotient << 1);
    remainder = value - times_ten;
    digit     = remainder[dvsd_pkg::DigitW-1:0];
  end

endmodule

FILE: rtl/dual_value_seven_segment_driver.sv
// Dual-value seven-segment display driver.
// The item channel carries one beat with measured_value and target_value.
// Each beat becomes a run of display frames on the frame channel, one frame
// per display position: the low decimal digits of measured_value at positions
// 0 up, then those of target_value, least significant digit first, at most
// eight frames. The decimal point is lit on the second digit of each value.
// last_frame marks the final frame of each run.
// The item beat is loaded into the sequencer, which registers each frame into
// the output register. Throughput: one frame per cycle while the receiver is
// ready; an item makes min(2*DIGITS_PER_VALUE, 8) frames (8 at the default), and
// the sequencer's single divide-by-ten unit yields one digit per cycle unless
// stalled. The next item is accepted in the cycle the last frame is registered.
// Reset clears busy, the position and the output valid flag; no frame is pending.
// When the receiver stalls, the output register holds its frame, the
// sequencer waits, and no item is accepted until the run can finish.
module dual_value_seven_segment_driver #(
  parameter int unsigned DIGITS_PER_VALUE = 4
) (
  input  logic        clk,
  input  logic        rst,
  dvsd_in_if.sink     item,
  dvsd_out_if.source  frame
);

  localparam int unsigned Frames =
    (2 * DIGITS_PER_VALUE > dvsd_pkg::Positions) ? dvsd_pkg::Positions : 2 * DIGITS_PER_VALUE;

  // Sequencer state.
  logic                          busy;
  logic [dvsd_pkg::PosW-1:0]     pos;
  logic [dvsd_pkg::ValueW-1:0]   value;
  logic [dvsd_pkg::ValueW-1:0]   target;

  // Output register.
  logic                          out_valid;
  dvsd_pkg::frame_t              out_frame;
  dvsd_pkg::frame_t              frame_next;

  logic [dvsd_pkg::ValueW-1:0]   quotient;
  logic [dvsd_pkg::DigitW-1:0]   digit;
  logic                          advance;
  logic                          at_last;
  logic                          at_switch;
  logic                          dp;
  logic                          accept;

  dvsd_div10 u_div10 (
    .value    (value),
    .quotient (quotient),
    .digit    (digit)
  );

  // Handshake and sequencing conditions.
  always_comb begin
    advance   = busy && (!out_valid || frame.ready);
    at_last   = (pos == dvsd_pkg::PosW'(Frames - 1));
    at_switch = (pos == dvsd_pkg::PosW'(DIGITS_PER_VALUE - 1));
    dp        = (DIGITS_PER_VALUE > 1) &&
                ((pos == dvsd_pkg::PosW'(1)) ||
                 (pos == dvsd_pkg::PosW'(DIGITS_PER_VALUE + 1)));
  end

  assign item.ready = !busy || (advance && at_last);
  assign accept     = item.valid && item.ready;

  // Frame for the current position.
  always_comb begin
    frame_next.digit_select = dvsd_pkg::Positions'(1) << pos;
    frame_next.segments     = dvsd_pkg::seg_pattern(digit) ^ (dp ? dvsd_pkg::DpBit : '0);
    frame_next.last_frame   = at_last;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (advance) begin
        if (at_last) begin
          busy <= 1'b0;
        end
        pos <= pos + 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: working value, pending target and the frame.
  always_ff @(posedge clk) begin
    if (accept) begin
      value  <= item.measured_value;
      target <= item.target_value;
    end else if (advance) begin
      value <= at_switch ? target : quotient;
    end
    if (advance) begin
      out_frame <= frame_next;
    end
  end

  assign frame.valid        = out_valid;
  assign frame.digit_select = out_frame.digit_select;
  assign frame.segments     = out_frame.segments;
  assign frame.last_frame   = out_frame.last_frame;

endmodule

FILE: rtl/dvsd_checker.sv
`include "assert_macros.svh"

module dvsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       frame_valid,
  input logic       frame_ready,
  input logic [7:0] digit_select,
  input logic [7:0] segments,
  input logic       last_frame
);

  logic frame_beat;
  assign frame_beat = frame_valid && frame_ready;

  // Every shown frame enables exactly one position.
  `DVSD_ASSERT(a_select_onehot, clk, rst, !frame_valid || $onehot(digit_select))

  // A stalled frame keeps its contents.
  `DVSD_ASSERT_NEXT(a_stall_holds, clk, rst, frame_valid && !frame_ready,
                    frame_valid && $stable(digit_select) && $stable(segments) &&
                    $stable(last_frame))

  // Within a run the next frame follows at once, one position higher.
  `DVSD_ASSERT_NEXT(a_run_steps, clk, rst, frame_beat && !last_frame,
                    frame_valid && (digit_select == ($past(digit_select) << 1)))

  // A new run starts at position zero.
  `DVSD_ASSERT_NEXT(a_run_restarts, clk, rst, frame_beat && last_frame,
                    !frame_valid || (digit_select == 8'h01))

  // An item is taken only when the output register is free, moving on, or
  // holds the last frame of a run.
  `DVSD_ASSERT(a_item_when_free, clk, rst,
               !(item_valid && item_ready) || !frame_valid || frame_ready || last_frame)

endmodule

bind dual_value_seven_segment_driver dvsd_checker u_dvsd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .frame_valid  (frame.valid),
  .frame_ready  (frame.ready),
  .digit_select (frame.digit_select),
  .segments     (frame.segments),
  .last_frame   (frame.last_frame)
);
